FILE: src/block_buffer_cache_refcount_macros.svh
// Assertion helpers used by the file that checks the buffer cache.
`ifndef BLOCK_BUFFER_CACHE_REFCOUNT_MACROS_SVH
`define BLOCK_BUFFER_CACHE_REFCOUNT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bbc_pkg.sv
package bbc_pkg;

    localparam int BUFFERS = 32;
    localparam int GROUP   = 8;
    localparam int NGRP    = (BUFFERS + GROUP - 1) / GROUP;
    localparam int BIDX_W  = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
    localparam int GIDX_W  = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam logic [7:0] REFS_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOBUF = 2'd1,
        ST_UNDER = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_PICK = 2'd2,
        S_DONE = 2'd3
    } t_state;

    typedef struct packed {
        logic key_we;
        logic valid_set;
        logic refs_we;
    } t_cell_wr;

    typedef struct packed {
        logic [7:0] refs;
        logic       valid;
        logic       first_free;
        logic       last_match;
    } t_cell_st;

endpackage

FILE: src/bbc_cell.sv
module bbc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_dev,
    input  logic [31:0]       i_blk,
    input  logic              i_cmp,
    input  logic              i_free_below,
    input  logic              i_match_above,
    output logic              o_free_below,
    output logic              o_match_above,
    input  bbc_pkg::t_cell_wr i_wr,
    input  logic [7:0]        i_refs,
    output bbc_pkg::t_cell_st o_st
);

    logic [7:0]  r_dev;
    logic [31:0] r_blk;
    logic        r_valid;
    logic [7:0]  r_refs;
    logic        r_match;
    logic        r_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev   <= '0;
            r_blk   <= '0;
            r_valid <= 1'b0;
            r_refs  <= '0;
            r_match <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            if (i_cmp) begin
                r_match <= (r_dev == i_dev) && (r_blk == i_blk);
                r_free  <= (r_refs == 8'd0);
            end
            if (i_wr.key_we) begin
                r_dev <= i_dev;
                r_blk <= i_blk;
            end
            if (i_wr.valid_set) begin
                r_valid <= 1'b1;
            end
            if (i_wr.refs_we) begin
                r_refs <= i_refs;
            end
        end
    end

    // The free flag ripples upward and the match flag downward within a group.
    assign o_free_below  = i_free_below | r_free;
    assign o_match_above = i_match_above | r_match;

    assign o_st.refs       = r_refs;
    assign o_st.valid      = r_valid;
    assign o_st.first_free = r_free & ~i_free_below;
    assign o_st.last_match = r_match & ~i_match_above;

endmodule

FILE: src/block_buffer_cache_refcount.sv
// Channel   Direction  Handshake              Payload
// request   in         start high, busy low   i_operation i_device i_block_number
//                                             i_buffer_index
// result    out        o_valid, one cycle     o_entry o_hit o_needs_read o_ref_count
//                                             o_status
//
// The block takes no new item until it is through with the last one: the cells compare
// their keys, the in-group priority chains are registered, then the winner is updated.
// Its result is registered as the update is made and appears while busy is already low.
// Reset is synchronous and active low and clears every entry to device 0, block 0,
// invalid, count 0. The receiver cannot stall, so each result is shown once.
module block_buffer_cache_refcount (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_device,
    input  logic [31:0] i_block_number,
    input  logic [4:0]  i_buffer_index,
    output logic        o_valid,
    output logic [4:0]  o_entry,
    output logic        o_hit,
    output logic        o_needs_read,
    output logic [7:0]  o_ref_count,
    output logic [1:0]  o_status
);

    `include "block_buffer_cache_refcount_macros.svh"

    localparam int BUFFERS = bbc_pkg::BUFFERS;
    localparam int GROUP   = bbc_pkg::GROUP;
    localparam int NGRP    = bbc_pkg::NGRP;
    localparam int BIDX_W  = bbc_pkg::BIDX_W;
    localparam int GIDX_W  = bbc_pkg::GIDX_W;

    bbc_pkg::t_state r_state, n_state;

    bbc_pkg::t_op r_op;
    logic [7:0]   r_dev;
    logic [31:0]  r_blk;
    logic [4:0]   r_idx;

    logic              free_chain  [BUFFERS];
    logic              match_chain [BUFFERS];
    logic              free_in     [BUFFERS];
    logic              match_in    [BUFFERS];
    bbc_pkg::t_cell_st cell_st     [BUFFERS];
    bbc_pkg::t_cell_wr cell_wr     [BUFFERS];

    logic [BUFFERS-1:0] r_first_free;
    logic [BUFFERS-1:0] r_last_match;
    logic [NGRP-1:0]    r_gfree;
    logic [NGRP-1:0]    r_gmatch;
    logic [NGRP-1:0]    n_gfree;
    logic [NGRP-1:0]    n_gmatch;

    logic [4:0] r_out_entry;
    logic       r_out_hit;
    logic       r_out_nr;
    logic [7:0] r_out_refs;
    logic [1:0] r_out_status;
    logic       r_out_valid;

    logic [GIDX_W-1:0]  fgrp;
    logic [GIDX_W-1:0]  mgrp;
    logic [BUFFERS-1:0] hit_oh;
    logic [BUFFERS-1:0] free_oh;
    logic [BIDX_W-1:0]  hit_idx;
    logic [BIDX_W-1:0]  free_idx;
    logic [BIDX_W-1:0]  n_sel;
    logic               any_match;
    logic               any_free;
    logic               in_range;
    logic [7:0]         cur_refs;
    logic               cur_valid;
    logic [7:0]         n_refs;
    bbc_pkg::t_cell_wr  n_cmd;
    logic [4:0]         n_entry;
    logic               n_hit;
    logic               n_nr;
    logic [7:0]         n_out_refs;
    bbc_pkg::t_status   n_status;
    logic [31:0]        sel_wide;

    genvar gi;
    generate
        for (gi = 0; gi < BUFFERS; gi++) begin : g_cell
            if ((gi % GROUP) == 0) begin : g_fb
                assign free_in[gi] = 1'b0;
            end else begin : g_fc
                assign free_in[gi] = free_chain[gi-1];
            end
            if (((gi % GROUP) == GROUP - 1) || (gi == BUFFERS - 1)) begin : g_mb
                assign match_in[gi] = 1'b0;
            end else begin : g_mc
                assign match_in[gi] = match_chain[gi+1];
            end
            bbc_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_dev         (r_dev),
                .i_blk         (r_blk),
                .i_cmp         (r_state == bbc_pkg::S_CMP),
                .i_free_below  (free_in[gi]),
                .i_match_above (match_in[gi]),
                .o_free_below  (free_chain[gi]),
                .o_match_above (match_chain[gi]),
                .i_wr          (cell_wr[gi]),
                .i_refs        (n_refs),
                .o_st          (cell_st[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bbc_pkg::S_IDLE: begin
                if (start) begin
                    n_state = bbc_pkg::S_CMP;
                end
            end
            bbc_pkg::S_CMP:  n_state = bbc_pkg::S_PICK;
            bbc_pkg::S_PICK: n_state = bbc_pkg::S_DONE;
            bbc_pkg::S_DONE: n_state = bbc_pkg::S_IDLE;
            default:         n_state = bbc_pkg::S_IDLE;
        endcase
    end

    assign busy = (r_state != bbc_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (r_state == bbc_pkg::S_IDLE && start) begin
            r_op  <= bbc_pkg::t_op'(i_operation);
            r_dev <= i_device;
            r_blk <= i_block_number;
            r_idx <= i_buffer_index;
        end
    end

    always_comb begin
        n_gfree  = '0;
        n_gmatch = '0;
        for (int i = 0; i < BUFFERS; i++) begin
            n_gfree[i/GROUP]  = n_gfree[i/GROUP] | cell_st[i].first_free;
            n_gmatch[i/GROUP] = n_gmatch[i/GROUP] | cell_st[i].last_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bbc_pkg::S_PICK) begin
            for (int i = 0; i < BUFFERS; i++) begin
                r_first_free[i] <= cell_st[i].first_free;
                r_last_match[i] <= cell_st[i].last_match;
            end
            r_gfree  <= n_gfree;
            r_gmatch <= n_gmatch;
        end
    end

    always_comb begin
        fgrp = '0;
        mgrp = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_gfree[g]) begin
                fgrp = GIDX_W'(g);
            end
        end
        for (int g = 0; g < NGRP; g++) begin
            if (r_gmatch[g]) begin
                mgrp = GIDX_W'(g);
            end
        end
        any_free  = |r_gfree;
        any_match = |r_gmatch;

        hit_oh   = '0;
        free_oh  = '0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < BUFFERS; i++) begin
            hit_oh[i]  = r_last_match[i] && (GIDX_W'(i / GROUP) == mgrp);
            free_oh[i] = r_first_free[i] && (GIDX_W'(i / GROUP) == fgrp);
            if (hit_oh[i]) begin
                hit_idx = hit_idx | BIDX_W'(i);
            end
            if (free_oh[i]) begin
                free_idx = free_idx | BIDX_W'(i);
            end
        end

        in_range = (32'(r_idx) < BUFFERS);
        if (r_op == bbc_pkg::OP_GET) begin
            n_sel = any_match ? hit_idx : free_idx;
        end else begin
            n_sel = BIDX_W'(r_idx);
        end

        cur_refs  = '0;
        cur_valid = 1'b0;
        for (int i = 0; i < BUFFERS; i++) begin
            if (n_sel == BIDX_W'(i)) begin
                cur_refs  = cur_refs | cell_st[i].refs;
                cur_valid = cur_valid | cell_st[i].valid;
            end
        end
        sel_wide = 32'(n_sel);

        n_cmd      = '0;
        n_refs     = cur_refs;
        n_entry    = sel_wide[4:0];
        n_hit      = 1'b0;
        n_nr       = 1'b0;
        n_out_refs = cur_refs;
        n_status   = bbc_pkg::ST_OK;

        case (r_op)
            bbc_pkg::OP_GET: begin
                if (any_match) begin
                    n_hit           = 1'b1;
                    n_nr            = ~cur_valid;
                    n_cmd.valid_set = 1'b1;
                    if (cur_refs == bbc_pkg::REFS_MAX) begin
                        n_status = bbc_pkg::ST_SAT;
                    end else begin
                        n_refs        = cur_refs + 8'd1;
                        n_cmd.refs_we = 1'b1;
                    end
                    n_out_refs = n_refs;
                end else if (any_free) begin
                    n_nr            = 1'b1;
                    n_refs          = 8'd1;
                    n_out_refs      = 8'd1;
                    n_cmd.key_we    = 1'b1;
                    n_cmd.valid_set = 1'b1;
                    n_cmd.refs_we   = 1'b1;
                end else begin
                    n_entry    = '0;
                    n_out_refs = '0;
                    n_status   = bbc_pkg::ST_NOBUF;
                end
            end
            bbc_pkg::OP_PIN: begin
                n_entry = r_idx;
                if (!in_range) begin
                    n_out_refs = '0;
                    n_status   = bbc_pkg::ST_NOBUF;
                end else if (cur_refs == bbc_pkg::REFS_MAX) begin
                    n_status = bbc_pkg::ST_SAT;
                end else begin
                    n_refs        = cur_refs + 8'd1;
                    n_out_refs    = n_refs;
                    n_cmd.refs_we = 1'b1;
                end
            end
            default: begin
                n_entry = r_idx;
                if (!in_range) begin
                    n_out_refs = '0;
                    n_status   = bbc_pkg::ST_NOBUF;
                end else if (cur_refs == 8'd0) begin
                    n_status = bbc_pkg::ST_UNDER;
                end else begin
                    n_refs        = cur_refs - 8'd1;
                    n_out_refs    = n_refs;
                    n_cmd.refs_we = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < BUFFERS; i++) begin
            if ((r_state == bbc_pkg::S_DONE) && (n_sel == BIDX_W'(i))) begin
                cell_wr[i] = n_cmd;
            end else begin
                cell_wr[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == bbc_pkg::S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bbc_pkg::S_DONE) begin
            r_out_entry  <= n_entry;
            r_out_hit    <= n_hit;
            r_out_nr     <= n_nr;
            r_out_refs   <= n_out_refs;
            r_out_status <= n_status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_entry      = r_out_entry;
    assign o_hit        = r_out_hit;
    assign o_needs_read = r_out_nr;
    assign o_ref_count  = r_out_refs;
    assign o_status     = r_out_status;

    `BBC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted beat did not raise busy.")
    `BBC_ASSERT_SAME(a_result_after_done, o_valid, $past(r_state == bbc_pkg::S_DONE), "Result strobe without a finished update.")
    `BBC_ASSERT_SAME(a_single_hit, r_state == bbc_pkg::S_DONE, $onehot0(hit_oh) && $onehot0(free_oh), "More than one winning entry.")
    `BBC_ASSERT_SAME(a_hit_status, o_valid && o_hit, (o_status == 2'(bbc_pkg::ST_OK)) || (o_status == 2'(bbc_pkg::ST_SAT)), "Hit reported with an error status.")

endmodule

FILE: tb/sv/block_buffer_cache_refcount_tb.sv
`timescale 1ns / 100ps

module block_buffer_cache_refcount_tb;

    typedef struct packed {
        logic [4:0]       entry;
        logic             hit;
        logic             needs_read;
        logic [7:0]       ref_count;
        bbc_pkg::t_status status;
    } t_lookup_result;

    class cache_scoreboard;
        bit [7:0]       key_dev [bbc_pkg::BUFFERS];
        bit [31:0]      key_blk [bbc_pkg::BUFFERS];
        bit             filled  [bbc_pkg::BUFFERS];
        bit [7:0]       refs    [bbc_pkg::BUFFERS];
        t_lookup_result awaited [$];
        int             errors;
        int             checked;
        int             hits;
        int             misses;
        int             nobuf;
        int             underflows;
        int             saturations;
        int             last_entry;

        function void note_request(bbc_pkg::t_op op, bit [7:0] dev, bit [31:0] blk,
                                   bit [4:0] idx);
            t_lookup_result r;
            int             found;
            int             i;
            found = -1;
            r = '{entry: 5'd0, hit: 1'b0, needs_read: 1'b0, ref_count: 8'd0,
                  status: bbc_pkg::ST_OK};
            if (op == bbc_pkg::OP_GET) begin
                for (i = 0; i < bbc_pkg::BUFFERS; i++) begin
                    if (key_dev[i] == dev && key_blk[i] == blk) begin
                        found = i;
                    end
                end
                if (found >= 0) begin
                    hits++;
                    r.entry = 5'(found);
                    r.hit = 1'b1;
                    r.needs_read = !filled[found];
                    if (refs[found] == bbc_pkg::REFS_MAX) begin
                        r.status = bbc_pkg::ST_SAT;
                    end else begin
                        refs[found]++;
                    end
                    filled[found] = 1'b1;
                    r.ref_count = refs[found];
                end else begin
                    for (i = 0; i < bbc_pkg::BUFFERS; i++) begin
                        if (refs[i] == 8'd0 && found < 0) begin
                            found = i;
                        end
                    end
                    if (found >= 0) begin
                        misses++;
                        key_dev[found] = dev;
                        key_blk[found] = blk;
                        refs[found] = 8'd1;
                        filled[found] = 1'b1;
                        r.entry = 5'(found);
                        r.needs_read = 1'b1;
                        r.ref_count = 8'd1;
                    end else begin
                        nobuf++;
                        r.status = bbc_pkg::ST_NOBUF;
                    end
                end
            end else if (int'(idx) >= bbc_pkg::BUFFERS) begin
                r.entry = idx;
                r.status = bbc_pkg::ST_NOBUF;
            end else begin
                found = int'(idx);
                if (op == bbc_pkg::OP_PIN) begin
                    if (refs[found] == bbc_pkg::REFS_MAX) begin
                        r.status = bbc_pkg::ST_SAT;
                    end else begin
                        refs[found]++;
                    end
                end else begin
                    if (refs[found] == 8'd0) begin
                        r.status = bbc_pkg::ST_UNDER;
                    end else begin
                        refs[found]--;
                    end
                end
                r.entry = idx;
                r.ref_count = refs[found];
            end
            if (r.status == bbc_pkg::ST_SAT) begin
                saturations++;
            end
            if (r.status == bbc_pkg::ST_UNDER) begin
                underflows++;
            end
            last_entry = found;
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want,
                         got);
                errors++;
            end
        endfunction

        function void check_result(t_lookup_result got);
            t_lookup_result want;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none,",
                         $time, " actual entry %0d status %0d", got.entry, got.status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare_field("entry", want.entry, got.entry);
            compare_field("hit", want.hit, got.hit);
            compare_field("needs_read", want.needs_read, got.needs_read);
            compare_field("ref_count", want.ref_count, got.ref_count);
            compare_field("status", want.status, got.status);
        endfunction

        function int pick_entry(bit held);
            int cand [$];
            int i;
            for (i = 0; i < bbc_pkg::BUFFERS; i++) begin
                if ((refs[i] != 8'd0) == held) begin
                    cand.push_back(i);
                end
            end
            if (cand.size() == 0) begin
                return $urandom_range(bbc_pkg::BUFFERS - 1);
            end
            return cand[$urandom_range(cand.size() - 1)];
        endfunction

        function int free_count();
            int n;
            int i;
            n = 0;
            for (i = 0; i < bbc_pkg::BUFFERS; i++) begin
                if (refs[i] == 8'd0) begin
                    n++;
                end
            end
            return n;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [7:0]  i_device;
    logic [31:0] i_block_number;
    logic [4:0]  i_buffer_index;
    logic        o_valid;
    logic [4:0]  o_entry;
    logic        o_hit;
    logic        o_needs_read;
    logic [7:0]  o_ref_count;
    logic [1:0]  o_status;

    cache_scoreboard sb = new();
    int              sent;
    bit              quiet;
    bit [7:0]        pool_dev [16];
    bit [31:0]       pool_blk [16];

    block_buffer_cache_refcount dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_buffer_index (i_buffer_index),
        .o_valid        (o_valid),
        .o_entry        (o_entry),
        .o_hit          (o_hit),
        .o_needs_read   (o_needs_read),
        .o_ref_count    (o_ref_count),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_lookup_result got;
        if (i_rst_n && o_valid) begin
            got = '{entry: o_entry, hit: o_hit, needs_read: o_needs_read,
                    ref_count: o_ref_count, status: bbc_pkg::t_status'(o_status)};
            sb.check_result(got);
        end
    end

    task automatic send_request(bbc_pkg::t_op op, logic [7:0] dev, logic [31:0] blk,
                                logic [4:0] idx);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 26) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_device <= dev;
        i_block_number <= blk;
        i_buffer_index <= idx;
        do @(posedge i_clk); while (busy);
        sb.note_request(op, dev, blk, idx);
        sent++;
    endtask

    task automatic send_indexed(bbc_pkg::t_op op, int idx);
        send_request(op, 8'($urandom), $urandom, 5'(idx));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.awaited.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic pool_burst();
        int n;
        int k;
        int p;
        n = $urandom_range(1, 8);
        repeat (n) begin
            k = $urandom_range(9);
            p = $urandom_range(15);
            if (k < 5) begin
                send_request(bbc_pkg::OP_GET, pool_dev[p], pool_blk[p], 5'($urandom));
            end else if (k < 7) begin
                send_indexed(bbc_pkg::t_op'($urandom_range(1) ? bbc_pkg::OP_RELEASE
                                                              : bbc_pkg::OP_UNPIN),
                             sb.pick_entry(1'b1));
            end else if (k < 9) begin
                send_indexed(bbc_pkg::OP_PIN,
                             $urandom_range(1) ? sb.pick_entry(1'b1) : $urandom_range(31));
            end else begin
                send_request(bbc_pkg::OP_GET, 8'($urandom), $urandom, 5'($urandom));
            end
        end
    endtask

    task automatic saturate_entry();
        logic [7:0]  dev;
        logic [31:0] blk;
        int          e;
        dev = 8'($urandom);
        blk = $urandom;
        send_request(bbc_pkg::OP_GET, dev, blk, 5'($urandom));
        e = sb.last_entry;
        if (e >= 0) begin
            repeat (256) send_indexed(bbc_pkg::OP_PIN, e);
            send_request(bbc_pkg::OP_GET, dev, blk, 5'($urandom));
            send_request(bbc_pkg::OP_GET, dev, blk, 5'($urandom));
            repeat (3) send_indexed(bbc_pkg::OP_UNPIN, e);
        end
    endtask

    initial begin
        int sel;
        int i;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = bbc_pkg::OP_GET;
        i_device = '0;
        i_block_number = '0;
        i_buffer_index = '0;
        sent = 0;
        quiet = 1'b0;
        pool_dev[0] = 8'h00;
        pool_blk[0] = 32'h0;
        pool_dev[1] = 8'hFF;
        pool_blk[1] = 32'hFFFF_FFFF;
        for (i = 2; i < 16; i++) begin
            pool_dev[i] = 8'($urandom_range(3));
            pool_blk[i] = $urandom_range(1) ? $urandom : $urandom_range(15);
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(bbc_pkg::OP_GET, 8'h00, 32'h0, 5'd0);
        send_request(bbc_pkg::OP_GET, 8'h00, 32'h0, 5'd31);
        send_request(bbc_pkg::OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
        send_request(bbc_pkg::OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_request(bbc_pkg::OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd5);
        send_request(bbc_pkg::OP_UNPIN, 8'h00, 32'h0, 5'd5);
        send_request(bbc_pkg::OP_PIN, 8'h00, 32'h0, 5'd5);
        send_request(bbc_pkg::OP_GET, 8'h00, 32'h0, 5'd0);
        send_request(bbc_pkg::OP_UNPIN, 8'h00, 32'h0, 5'd31);
        send_request(bbc_pkg::OP_RELEASE, 8'h00, 32'h0, 5'd31);
        send_request(bbc_pkg::OP_RELEASE, 8'h00, 32'h0, 5'd31);
        send_request(bbc_pkg::OP_RELEASE, 8'h00, 32'h0, 5'd31);
        send_request(bbc_pkg::OP_GET, 8'h00, 32'h0, 5'd0);
        send_request(bbc_pkg::OP_PIN, 8'hAA, 32'h5555_5555, 5'd0);
        send_request(bbc_pkg::OP_RELEASE, 8'h55, 32'hAAAA_AAAA, 5'd0);
        send_request(bbc_pkg::OP_GET, 8'h80, 32'h8000_0000, 5'd16);
        send_request(bbc_pkg::OP_GET, 8'h7F, 32'h7FFF_FFFF, 5'd15);
        send_request(bbc_pkg::OP_GET, 8'h01, 32'h0000_0001, 5'd1);
        send_request(bbc_pkg::OP_UNPIN, 8'h00, 32'h0, 5'd1);
        send_request(bbc_pkg::OP_RELEASE, 8'h00, 32'h0, 5'd5);
        drain_results();

        saturate_entry();

        while (sent < 1100) begin
            quiet = (sent >= 500 && sent < 700);
            sel = $urandom_range(99);
            if (sel < 45) begin
                pool_burst();
            end else if (sel < 60) begin
                for (i = 0; i < bbc_pkg::BUFFERS; i++) begin
                    if (sb.refs[i] != 8'd0 && $urandom_range(9) < 7) begin
                        send_indexed(bbc_pkg::OP_RELEASE, i);
                    end
                end
            end else if (sel < 72) begin
                repeat (sb.free_count() + $urandom_range(1, 4)) begin
                    send_request(bbc_pkg::OP_GET, 8'($urandom), $urandom, 5'($urandom));
                end
            end else if (sel < 85) begin
                repeat ($urandom_range(1, 6)) begin
                    send_request(bbc_pkg::t_op'($urandom_range(3)), 8'($urandom), $urandom,
                                 5'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_indexed(bbc_pkg::t_op'($urandom_range(1) ? bbc_pkg::OP_RELEASE
                                                                  : bbc_pkg::OP_UNPIN),
                                 sb.pick_entry(1'b0));
                end
            end
            if ($urandom_range(19) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d results from %0d requests: %0d hits, %0d misses,",
                 sb.checked, sent, sb.hits, sb.misses,
                 " %0d with no free buffer.", sb.nobuf);
        $display("Reference counts underflowed %0d times and saturated %0d times.",
                 sb.underflows, sb.saturations);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/bbc_pkg.sv
src/bbc_cell.sv
src/block_buffer_cache_refcount.sv
tb/sv/block_buffer_cache_refcount_tb.sv
